// ===== rtl/btpc_pkg.sv =====
// Shared types and constants for the barometric compensation core.
// No dependencies; used by btpc_arith and the top level.
package btpc_pkg;

  // Width of the shared signed datapath
  localparam int ARITH_W = 72;
  // Steps of one shift-add multiply (width of the small operand)
  localparam int MUL_STEPS = 32;
  localparam int FRAC_BITS_DEF = 16;

  // Shared unit operation codes
  localparam logic ARITH_MUL = 1'b0;
  localparam logic ARITH_DIV = 1'b1;

  // Register indexes
  localparam logic [1:0] CFG_A = 2'd0;
  localparam logic [1:0] CFG_B = 2'd1;
  localparam logic [1:0] CFG_C = 2'd2;
  localparam logic [1:0] CFG_D = 2'd3;

  // Item operation codes
  localparam logic OP_TEMP = 1'b0;
  localparam logic OP_PRES = 1'b1;

  // Pressure offset 3783/1600 in 16 fraction bits, rounded
  localparam longint OFFS_NUM = 3791 - 8;
  localparam longint OFFS_DEN = 1600;
  localparam longint OFFS_Q16 = (OFFS_NUM * 65536 + OFFS_DEN / 2) / OFFS_DEN;

  typedef struct packed {
    logic start;
    logic op;
  } arith_req_t;

endpackage

// ===== rtl/btpc_arith.sv =====
// Shared iterative multiply / rounding-divide unit, one bit per cycle.
// Depends on btpc_pkg.
module btpc_arith (
  input  logic                                clk,
  input  logic                                rst_n,
  input  btpc_pkg::arith_req_t                req,
  input  logic signed [btpc_pkg::ARITH_W-1:0] a,
  input  logic signed [btpc_pkg::ARITH_W-1:0] b,
  output logic                                busy,
  output logic                                done,
  output logic signed [btpc_pkg::ARITH_W-1:0] res
);

  localparam int W  = btpc_pkg::ARITH_W;
  localparam int MS = btpc_pkg::MUL_STEPS;
  localparam int CW = $clog2(W + 1);

  logic          busy_r, done_r, op_r, neg_r;
  logic [W-1:0]  x_r;    // multiplicand, or numerator / quotient
  logic [W-1:0]  y_r;    // divisor magnitude
  logic [MS-1:0] m_r;    // multiplier bits
  logic [W-1:0]  acc_r;
  logic [W:0]    rem_r;
  logic [CW-1:0] cnt_r;

  logic [W-1:0]  am, bm, mag;
  logic [W:0]    rem_sh;
  logic          ge;

  assign am     = a[W-1] ? W'(-a) : W'(a);
  assign bm     = b[W-1] ? W'(-b) : W'(b);
  assign rem_sh = {rem_r[W-1:0], x_r[W-1]};
  assign ge     = rem_sh >= {1'b0, y_r};
  assign mag    = (op_r == btpc_pkg::ARITH_DIV) ? x_r : acc_r;
  assign res    = neg_r ? -signed'(mag) : signed'(mag);
  assign busy   = busy_r;
  assign done   = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= (req.op == btpc_pkg::ARITH_DIV) ? CW'(W) : CW'(MS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      op_r  <= req.op;
      neg_r <= a[W-1] ^ b[W-1];
      acc_r <= '0;
      rem_r <= '0;
      m_r   <= bm[MS-1:0];
      y_r   <= bm;
      // rounding to nearest: add half the divisor up front
      x_r   <= (req.op == btpc_pkg::ARITH_DIV) ? am + (bm >> 1) : am;
    end else if (busy_r) begin
      if (op_r == btpc_pkg::ARITH_DIV) begin
        rem_r <= ge ? rem_sh - {1'b0, y_r} : rem_sh;
        x_r   <= {x_r[W-2:0], ge};
      end else begin
        if (m_r[0]) acc_r <= acc_r + x_r;
        x_r <= x_r << 1;
        m_r <= m_r >> 1;
      end
    end
  end

endmodule

// ===== rtl/barometric_temp_pressure_compensation_core.sv =====
// Barometric temperature / pressure compensation core. Depends on btpc_pkg
// and btpc_arith (shared multiply/divide unit).
//
// One item is worked at a time; in_ready is low from acceptance until the
// result has been moved into the output register. The variable products and
// all divides go through one shared unit that multiplies one multiplier bit
// per cycle and divides one quotient bit per cycle, after a setup step each.
// A temperature item takes one multiply and two divides (only the multiply
// when the divisor is zero). A pressure item takes eight multiplies and two
// divides. The result lands in an output register, and the next item is
// accepted while it waits to be taken. Calibration words are written through
// cfg_we/cfg_index/cfg_wdata; the user must write them only while no item is
// in flight, as the block itself does not enforce this. A pressure item uses
// the temperature left by the most recent good temperature item (zero after reset).
module barometric_temp_pressure_compensation_core #(
  parameter int FRAC_BITS = btpc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [47:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [23:0]        in_raw_reading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic signed [23:0] out_temperature,
  output logic [26:0]        out_pressure,
  output logic               out_error
);

  localparam int W = btpc_pkg::ARITH_W;
  localparam int SH_UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_DN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  localparam longint S_LIM   = longint'(1) << 27;
  localparam longint Z_LIM   = longint'(1) << 36;
  localparam longint T_MAX   = 8388607;
  localparam longint T_MIN   = -8388608;
  localparam longint P_MAX   = 134217727;
  localparam longint DEG_Q16 = 25 * 65536;
  localparam longint QQ_BASE = (longint'(1) << 24) - 7357 * 16;
  localparam longint W_BASE  = longint'(1) << 30;
  localparam longint TDIV    = longint'(5) << 20;
  localparam longint YDIV    = 1000 * 16384;

  // Sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_T_LIN = 4'd1;
  localparam logic [3:0] S_T_D1  = 4'd2;
  localparam logic [3:0] S_T_D2  = 4'd3;
  localparam logic [3:0] S_P_SQ  = 4'd4;
  localparam logic [3:0] S_P_X1  = 4'd5;
  localparam logic [3:0] S_P_X2  = 4'd6;
  localparam logic [3:0] S_P_W1  = 4'd7;
  localparam logic [3:0] S_P_W2  = 4'd8;
  localparam logic [3:0] S_P_Y   = 4'd9;
  localparam logic [3:0] S_P_YD  = 4'd10;
  localparam logic [3:0] S_P_Z   = 4'd11;
  localparam logic [3:0] S_P_Q   = 4'd12;
  localparam logic [3:0] S_P_P   = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  // Round to nearest, ties away from zero, on a right shift
  function automatic logic signed [W-1:0] rnd_shr(input logic signed [W-1:0] v,
                                                  input int k);
    logic [W-1:0] mag;
    logic [W-1:0] half;
    mag  = v[W-1] ? W'(-v) : W'(v);
    half = (k == 0) ? '0 : (W'(1) << (k - 1));
    mag  = (mag + half) >> k;
    return v[W-1] ? -signed'(mag) : signed'(mag);
  endfunction

  // Calibration registers
  logic [47:0] cfg_a_r, cfg_b_r;
  logic [31:0] cfg_c_r, cfg_d_r;

  logic signed [W-1:0] ac1_w, ac2_w, ac3_w, ac4_w, ac5_w, ac6_w;
  logic signed [W-1:0] b1_w, b2_w, mc_w, md_w;

  assign ac1_w = W'(signed'(cfg_a_r[47:32]));
  assign ac2_w = W'(signed'(cfg_a_r[31:16]));
  assign ac3_w = W'(signed'(cfg_a_r[15:0]));
  assign ac4_w = signed'(W'(cfg_b_r[47:32]));
  assign ac5_w = signed'(W'(cfg_b_r[31:16]));
  assign ac6_w = signed'(W'(cfg_b_r[15:0]));
  assign b1_w  = W'(signed'(cfg_c_r[31:16]));
  assign b2_w  = W'(signed'(cfg_c_r[15:0]));
  assign mc_w  = W'(signed'(cfg_d_r[31:16]));
  assign md_w  = W'(signed'(cfg_d_r[15:0]));

  // Sequencer and datapath registers
  logic [3:0]          state_r, state_nxt;
  logic                op_r, op_nxt;
  logic [23:0]         raw_r, raw_nxt;
  logic signed [W-1:0] part_r, part_nxt;   // T divisor, T first term, x/w partial sums
  logic signed [W-1:0] sft_r, sft_nxt;
  logic signed [W-1:0] sq_r, sq_nxt;
  logic signed [W-1:0] xq_r, xq_nxt;
  logic signed [W-1:0] zq_r, zq_nxt;
  logic signed [23:0]  last_temp_r, last_temp_nxt;
  logic signed [23:0]  fin_temp_r, fin_temp_nxt;
  logic [26:0]         fin_pres_r, fin_pres_nxt;
  logic                fin_err_r, fin_err_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r, out_kind_nxt;
  logic signed [23:0]  out_temp_r, out_temp_nxt;
  logic [26:0]         out_pres_r, out_pres_nxt;
  logic                out_err_r, out_err_nxt;

  // Shared unit
  btpc_pkg::arith_req_t req;
  logic signed [W-1:0]  opa, opb, ares;
  logic                 abusy, adone;

  btpc_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .a     (opa),
    .b     (opb),
    .busy  (abusy),
    .done  (adone),
    .res   (ares)
  );

  // Datapath values formed from the unit's result
  logic signed [W-1:0] tq_w, s0_c, sft_c, den_c, tv_raw, sq_c, wq_c;
  logic signed [W-1:0] zq_c, qq_c, pq_c, pq_sh, num_c;
  logic signed [23:0]  tv_c;
  logic [26:0]         pfin_c;

  assign tq_w  = W'(last_temp_r);
  assign s0_c  = rnd_shr(tq_w <<< SH_DN, SH_UP) - W'(DEG_Q16);
  // temperature offset saturates to +-2^11 degrees
  assign sft_c = (s0_c > W'(S_LIM)) ? W'(S_LIM) :
                 (s0_c < -W'(S_LIM)) ? -W'(S_LIM) : s0_c;
  assign den_c = ares + (md_w <<< 15);
  assign tv_raw = part_r + ares;
  assign tv_c  = (tv_raw > W'(T_MAX)) ? 24'(T_MAX) :
                 (tv_raw < W'(T_MIN)) ? 24'(T_MIN) : tv_raw[23:0];
  assign sq_c  = rnd_shr(ares, 16);
  assign wq_c  = part_r + rnd_shr(ares, 24);
  assign num_c = (signed'(W'(raw_r)) <<< 8) - xq_r;
  assign zq_c  = (ares > W'(Z_LIM)) ? W'(Z_LIM) :
                 (ares < -W'(Z_LIM)) ? -W'(Z_LIM) : ares;
  assign qq_c  = W'(QQ_BASE) + rnd_shr(ares, 28);
  assign pq_c  = rnd_shr(ares, 24) + W'(btpc_pkg::OFFS_Q16);
  assign pq_sh = rnd_shr(pq_c <<< SH_UP, SH_DN);

  // Final pressure: negative to zero, scale to FRAC_BITS, saturate
  always_comb begin
    if (pq_c < 0) begin
      pfin_c = '0;
    end else if ((SH_DN == 0) && (pq_c > W'(P_MAX >>> SH_UP))) begin
      pfin_c = 27'(P_MAX);
    end else if (pq_sh > W'(P_MAX)) begin
      pfin_c = 27'(P_MAX);
    end else begin
      pfin_c = pq_sh[26:0];
    end
  end

  logic acc_in;
  assign acc_in   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    raw_nxt       = raw_r;
    part_nxt      = part_r;
    sft_nxt       = sft_r;
    sq_nxt        = sq_r;
    xq_nxt        = xq_r;
    zq_nxt        = zq_r;
    last_temp_nxt = last_temp_r;
    fin_temp_nxt  = fin_temp_r;
    fin_pres_nxt  = fin_pres_r;
    fin_err_nxt   = fin_err_r;
    req.start     = 1'b0;
    req.op        = btpc_pkg::ARITH_MUL;
    opa           = '0;
    opb           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          op_nxt       = in_operation;
          raw_nxt      = in_raw_reading;
          fin_pres_nxt = '0;
          fin_err_nxt  = 1'b0;
          req.start    = 1'b1;
          if (in_operation == btpc_pkg::OP_TEMP) begin
            // lin = ac5 * (ut - ac6)
            opa       = signed'(W'(in_raw_reading[15:0])) - ac6_w;
            opb       = ac5_w;
            state_nxt = S_T_LIN;
          end else begin
            fin_temp_nxt = last_temp_r;
            sft_nxt      = sft_c;
            opa          = sft_c;
            opb          = sft_c;
            state_nxt    = S_P_SQ;
          end
        end
      end
      S_T_LIN: begin
        if (adone) begin
          if (den_c == 0) begin
            fin_temp_nxt = '0;
            fin_err_nxt  = 1'b1;
            state_nxt    = S_OUT;
          end else begin
            part_nxt  = den_c;   // hold den for the second divide
            req.start = 1'b1;
            req.op    = btpc_pkg::ARITH_DIV;
            opa       = ares <<< FRAC_BITS;
            opb       = W'(TDIV);
            state_nxt = S_T_D1;
          end
        end
      end
      S_T_D1: begin
        if (adone) begin
          part_nxt  = ares;
          req.start = 1'b1;
          req.op    = btpc_pkg::ARITH_DIV;
          opa       = mc_w <<< (21 + FRAC_BITS);
          opb       = (part_r <<< 2) + part_r;
          state_nxt = S_T_D2;
        end
      end
      S_T_D2: begin
        if (adone) begin
          last_temp_nxt = tv_c;
          fin_temp_nxt  = tv_c;
          state_nxt     = S_OUT;
        end
      end
      S_P_SQ: begin
        if (adone) begin
          sq_nxt    = sq_c;
          req.start = 1'b1;
          opa       = sq_c;
          opb       = 25 * b2_w;
          state_nxt = S_P_X1;
        end
      end
      S_P_X1: begin
        if (adone) begin
          part_nxt  = rnd_shr(ares, 15);
          req.start = 1'b1;
          opa       = sft_r;
          opb       = 5 * ac2_w;
          state_nxt = S_P_X2;
        end
      end
      S_P_X2: begin
        if (adone) begin
          xq_nxt    = part_r + rnd_shr(ares, 8) + (ac1_w <<< 16);
          req.start = 1'b1;
          opa       = sft_r;
          opb       = 40 * ac3_w;
          state_nxt = S_P_W1;
        end
      end
      S_P_W1: begin
        if (adone) begin
          part_nxt  = W'(W_BASE) + rnd_shr(ares, 14);
          req.start = 1'b1;
          opa       = sq_r;
          opb       = 200 * b1_w;
          state_nxt = S_P_W2;
        end
      end
      S_P_W2: begin
        if (adone) begin
          req.start = 1'b1;
          opa       = wq_c;
          opb       = ac4_w;
          state_nxt = S_P_Y;
        end
      end
      S_P_Y: begin
        if (adone) begin
          req.start = 1'b1;
          req.op    = btpc_pkg::ARITH_DIV;
          opa       = ares;
          opb       = W'(YDIV);
          state_nxt = S_P_YD;
        end
      end
      S_P_YD: begin
        if (adone) begin
          if (ares == 0) begin
            fin_err_nxt = 1'b1;
            state_nxt   = S_OUT;
          end else begin
            req.start = 1'b1;
            req.op    = btpc_pkg::ARITH_DIV;
            opa       = num_c <<< 16;
            opb       = ares;
            state_nxt = S_P_Z;
          end
        end
      end
      S_P_Z: begin
        if (adone) begin
          zq_nxt    = zq_c;
          req.start = 1'b1;
          opa       = zq_c;
          opb       = W'(3038 * 100);
          state_nxt = S_P_Q;
        end
      end
      S_P_Q: begin
        if (adone) begin
          req.start = 1'b1;
          opa       = zq_r;
          opb       = qq_c;
          state_nxt = S_P_P;
        end
      end
      S_P_P: begin
        if (adone) begin
          fin_pres_nxt = pfin_c;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register: loads when the staged result can move out
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_temp_nxt  = out_temp_r;
    out_pres_nxt  = out_pres_r;
    out_err_nxt   = out_err_r;
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = op_r;
      out_temp_nxt  = fin_temp_r;
      out_pres_nxt  = fin_pres_r;
      out_err_nxt   = fin_err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_temp_r <= '0;
      cfg_a_r     <= '0;
      cfg_b_r     <= '0;
      cfg_c_r     <= '0;
      cfg_d_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_temp_r <= last_temp_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          btpc_pkg::CFG_A: cfg_a_r <= cfg_wdata;
          btpc_pkg::CFG_B: cfg_b_r <= cfg_wdata;
          btpc_pkg::CFG_C: cfg_c_r <= cfg_wdata[31:0];
          btpc_pkg::CFG_D: cfg_d_r <= cfg_wdata[31:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    raw_r      <= raw_nxt;
    part_r     <= part_nxt;
    sft_r      <= sft_nxt;
    sq_r       <= sq_nxt;
    xq_r       <= xq_nxt;
    zq_r       <= zq_nxt;
    fin_temp_r <= fin_temp_nxt;
    fin_pres_r <= fin_pres_nxt;
    fin_err_r  <= fin_err_nxt;
    out_kind_r <= out_kind_nxt;
    out_temp_r <= out_temp_nxt;
    out_pres_r <= out_pres_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_temperature = out_temp_r;
  assign out_pressure    = out_pres_r;
  assign out_error       = out_err_r;

  // One item in flight: no acceptance right after an acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // The shared unit is never restarted mid-operation
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    abusy |-> !req.start)
    else $error("shared unit started while busy");

  // Temperature items never carry a pressure value
  a_temp_no_pres: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == btpc_pkg::OP_TEMP) |-> (out_pressure == '0))
    else $error("temperature item with nonzero pressure");

  // A failed temperature item reports zero temperature
  a_temp_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error && out_kind == btpc_pkg::OP_TEMP) |->
      (out_temperature == '0))
    else $error("temperature error with nonzero temperature");

endmodule

// ===== dv/btpc_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the barometric compensation core: watches config writes
// and both item channels, predicts each result and compares. Uses btpc_pkg.
module btpc_result_checker #(
  parameter int FRAC_BITS = btpc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [47:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_operation,
  input  logic [23:0]        in_raw_reading,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_kind,
  input  logic signed [23:0] out_temperature,
  input  logic [26:0]        out_pressure,
  input  logic               out_error,
  output int                 mismatches,
  output int                 outstanding,
  output int                 results_seen
);

  typedef struct {
    logic               kind;
    logic signed [23:0] temperature;
    logic [26:0]        pressure;
    logic               error;
  } comp_result_t;

  localparam longint TEMP_MAX = 8388607;
  localparam longint TEMP_MIN = -8388608;
  localparam longint PRES_MAX = 134217727;

  logic [47:0] grp_a, grp_b;
  logic [31:0] grp_c, grp_d;
  longint      stored_temp;
  comp_result_t pending_results[$];

  // rounds to nearest, ties away from zero
  function automatic longint rdiv(longint n, longint d);
    longint un, ud, q;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = (un + ud / 2) / ud;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint s16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic comp_result_t compensate(logic op, logic [23:0] raw_in);
    comp_result_t r;
    longint raw, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    longint lin, den, tv, sft, sq, xq, wq, yq, zq, qq, pq;
    raw = longint'(raw_in);
    ac1 = s16(grp_a[47:32]); ac2 = s16(grp_a[31:16]); ac3 = s16(grp_a[15:0]);
    ac4 = longint'(grp_b[47:32]); ac5 = longint'(grp_b[31:16]);
    ac6 = longint'(grp_b[15:0]);
    b1 = s16(grp_c[31:16]); b2 = s16(grp_c[15:0]);
    mc = s16(grp_d[31:16]); md = s16(grp_d[15:0]);
    r.kind = op; r.temperature = '0; r.pressure = '0; r.error = 1'b0;
    if (op == btpc_pkg::OP_TEMP) begin
      lin = ac5 * ((raw & 64'hFFFF) - ac6);
      den = lin + md * 32768;
      if (den == 0) begin
        r.error = 1'b1;
        return r;
      end
      tv = rdiv(lin * (64'sd1 << FRAC_BITS), 5 * (64'sd1 << 20))
         + rdiv(mc * (64'sd1 << (21 + FRAC_BITS)), 5 * den);
      tv = clip(tv, TEMP_MIN, TEMP_MAX);
      stored_temp = tv;
      r.temperature = tv[23:0];
    end else begin
      r.temperature = stored_temp[23:0];
      if (FRAC_BITS >= 16) sft = rdiv(stored_temp, 64'sd1 << (FRAC_BITS - 16));
      else sft = stored_temp * (64'sd1 << (16 - FRAC_BITS));
      sft = clip(sft - 25 * 65536, -(64'sd1 << 27), 64'sd1 << 27);
      sq = rdiv(sft * sft, 65536);
      xq = rdiv(25 * b2 * sq, 64'sd1 << 15) + rdiv(5 * ac2 * sft, 256) + ac1 * 65536;
      wq = (64'sd1 << 30) + rdiv(40 * ac3 * sft, 64'sd1 << 14)
         + rdiv(200 * b1 * sq, 64'sd1 << 24);
      yq = rdiv(ac4 * wq, 64'sd1000 * 16384);
      if (yq == 0) begin
        r.error = 1'b1;
        return r;
      end
      zq = clip(rdiv((raw * 256 - xq) * 65536, yq), -(64'sd1 << 36), 64'sd1 << 36);
      qq = (64'sd1 << 24) - 7357 * 16 + rdiv(64'sd303800 * zq, 64'sd1 << 28);
      pq = rdiv(zq * qq, 64'sd1 << 24) + btpc_pkg::OFFS_Q16;
      if (pq < 0) pq = 0;
      if (FRAC_BITS >= 16) begin
        if (pq > (PRES_MAX >>> (FRAC_BITS - 16))) pq = PRES_MAX;
        else pq = pq * (64'sd1 << (FRAC_BITS - 16));
      end else begin
        pq = rdiv(pq, 64'sd1 << (16 - FRAC_BITS));
      end
      pq = clip(pq, 0, PRES_MAX);
      r.pressure = pq[26:0];
    end
    return r;
  endfunction

  assign outstanding = pending_results.size();

  always @(posedge clk) begin
    comp_result_t want;
    if (!rst_n) begin
      grp_a <= '0; grp_b <= '0; grp_c <= '0; grp_d <= '0;
      stored_temp = 0;
      pending_results.delete();
      mismatches <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          $error("result with nothing pending");
          mismatches <= mismatches + 1;
        end else begin
          want = pending_results.pop_front();
          if (out_kind !== want.kind || out_error !== want.error ||
              out_temperature !== want.temperature || out_pressure !== want.pressure)
            mismatches <= mismatches + 1;
          if (out_kind !== want.kind)
            $error("kind: expected %0d, got %0d", want.kind, out_kind);
          if (out_error !== want.error)
            $error("error: expected %0d, got %0d", want.error, out_error);
          if (out_temperature !== want.temperature)
            $error("temperature: expected %0d, got %0d", want.temperature,
                   out_temperature);
          if (out_pressure !== want.pressure)
            $error("pressure: expected %0d, got %0d", want.pressure, out_pressure);
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(compensate(in_operation, in_raw_reading));
      if (cfg_we) begin
        case (cfg_index)
          btpc_pkg::CFG_A: grp_a <= cfg_wdata;
          btpc_pkg::CFG_B: grp_b <= cfg_wdata;
          btpc_pkg::CFG_C: grp_c <= cfg_wdata[31:0];
          btpc_pkg::CFG_D: grp_d <= cfg_wdata[31:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Top of the barometric compensation testbench: clock, reset, calibration
// phases and item stimulus. Uses btpc_pkg, btpc_result_checker and the core.
module tb;

  localparam int  ITEMS_PER_PHASE = 100;
  localparam int  CYCLE_LIMIT = 3000000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = btpc_pkg::CFG_A;
  logic [47:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_operation = btpc_pkg::OP_TEMP;
  logic [23:0]        in_raw_reading = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_kind;
  logic signed [23:0] out_temperature;
  logic [26:0]        out_pressure;
  logic               out_error;
  int                 mismatches, outstanding, results_seen;
  int                 cycles = 0;
  int                 items_sent = 0;
  int                 phases_run = 0;
  logic [15:0]        cur_ac6 = '0;  // lets stimulus hit a zero temperature divisor

  always #6 clk = ~clk;

  barometric_temp_pressure_compensation_core uut (.*);

  btpc_result_checker chk (.*);

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: modes of always ready, coin flip, and long stalls
  int stall_mode = 0, stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(1, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // write enable stays high across a run of writes; the caller drops it
  task automatic cfg_write(logic [1:0] idx, logic [47:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == btpc_pkg::CFG_B) cur_ac6 = data[15:0];
    @(posedge clk);
  endtask

  // holds valid until the item is taken; caller decides on a gap
  task automatic push_item(logic op, logic [23:0] raw);
    in_valid <= 1'b1;
    in_operation <= op;
    in_raw_reading <= raw;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_calib(logic [47:0] a, logic [47:0] b, logic [31:0] c,
                            logic [31:0] d);
    cfg_write(btpc_pkg::CFG_A, a);
    cfg_write(btpc_pkg::CFG_B, b);
    cfg_write(btpc_pkg::CFG_C, {16'h0, c});
    cfg_write(btpc_pkg::CFG_D, {16'h0, d});
    cfg_we <= 1'b0;
    phases_run++;
  endtask

  // random items in bursts; mostly temperature-then-pressure pairs
  task automatic random_items(int n);
    int burst;
    logic [23:0] raw;
    burst = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        raw = 24'($urandom);
        if ($urandom_range(0, 15) == 0) raw[15:0] = cur_ac6;
        push_item(btpc_pkg::OP_TEMP, raw);
        raw = ($urandom_range(0, 1)) ? 24'($urandom) :
              24'($urandom_range(24'h500000, 24'hB00000));
        push_item(btpc_pkg::OP_PRES, raw);
        i++;
      end else begin
        push_item(1'($urandom), 24'($urandom));
      end
      if (--burst == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        burst = $urandom_range(1, 12);
      end
    end
  endtask

  initial begin
    logic [47:0] ra, rb;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset calibration: both divisors are zero, so every result is an error
    phases_run++;
    push_item(btpc_pkg::OP_TEMP, 24'h000000);
    push_item(btpc_pkg::OP_PRES, 24'hFFFFFF);
    settle();

    // typical factory words
    load_calib({16'd408, -16'sd72, -16'sd14383}, {16'd32741, 16'd32757, 16'd23153},
               {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
    push_item(btpc_pkg::OP_PRES, 24'h000000);  // pressure before any good temperature
    push_item(btpc_pkg::OP_TEMP, 24'h006CFA);
    push_item(btpc_pkg::OP_PRES, 24'h9D7000);
    push_item(btpc_pkg::OP_TEMP, 24'hFF0000);  // high bits ignored
    push_item(btpc_pkg::OP_TEMP, 24'h00FFFF);
    push_item(btpc_pkg::OP_PRES, 24'hFFFFFF);
    push_item(btpc_pkg::OP_PRES, 24'h000000);
    settle();

    // zero temperature divisor with ac5 = 1, md = 0, raw = ac6
    load_calib(48'h0, {16'd1, 16'd1, 16'd1234}, 32'h0, {16'd100, 16'd0});
    push_item(btpc_pkg::OP_TEMP, 24'd1234);
    push_item(btpc_pkg::OP_TEMP, 24'd1235);
    push_item(btpc_pkg::OP_PRES, 24'h800000);
    settle();

    // extremes of every word
    load_calib(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_items(ITEMS_PER_PHASE);
    settle();
    load_calib(48'h8000_8000_8000, 48'h8000_8000_8000, 32'h8000_8000, 32'h8000_8000);
    random_items(ITEMS_PER_PHASE);
    settle();
    load_calib(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_0000, 32'h7FFF_7FFF, 32'h7FFF_7FFF);
    random_items(ITEMS_PER_PHASE);
    settle();
    load_calib({16'd408, -16'sd72, -16'sd14383}, {16'd32741, 16'd32757, 16'd23153},
               {16'd6190, 16'd4}, {-16'sd8711, 16'd2868});
    random_items(ITEMS_PER_PHASE);
    settle();

    // random calibration words
    repeat (4) begin
      ra = 48'({$urandom, $urandom});
      rb = 48'({$urandom, $urandom});
      load_calib(ra, rb, $urandom, $urandom);
      random_items(ITEMS_PER_PHASE);
      settle();
    end

    repeat (200) @(posedge clk);
    $display("covered %0d items over %0d calibration settings, %0d results checked",
             items_sent, phases_run, results_seen);
    if (mismatches == 0 && outstanding == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
